// File: design/bcba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by the top level and the checker.
package bcba_pkg;

  localparam int OP_W       = 2;
  localparam int BLK_W      = 12;
  localparam int LEN_W      = 13;
  localparam int STAT_W     = 2;
  localparam int CFG_W      = 13;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_IDX_LSB = STAT_W;
  localparam int OUT_BIT_POS = STAT_W + BLK_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_TEST  = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

endpackage

// File: design/bitmap_contiguous_block_allocator_core.sv
// First-fit contiguous block allocator over a one-bit-per-block usage bitmap in RAM.
// Depends on bcba_pkg and bcba_ram. One request at a time; the result and ready come
// back together. Allocate scans the bitmap word by word (up to NUM_BLOCKS/WORD_BITS
// words), then read-modify-writes each word of the run. Free/mark read-modify-write
// each word touched; test reads one word. Range errors go straight to the result.
// Sync reset; a clearing pass zeroes the bitmap before the first request is taken.
// blocks_in_use resets to 4096.
module bitmap_contiguous_block_allocator_core
  import bcba_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // first_blk[11:0], run_length[24:12]
  input  logic [OP_W-1:0]       s_tuser,   // op[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // status[1:0], block_index[13:2], bit_value[14]
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW   = AW + 1;
  localparam int WB   = $clog2(WORD_BITS);
  localparam int JW   = WB + 1;
  localparam int LIMW = $clog2(NUM_BLOCKS + 1);
  localparam int PW   = (LIMW + 1 > LEN_W + 1) ? LIMW + 1 : LEN_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_RMW_RD, S_RMW_WR, S_TEST_RD, S_TEST_BIT, S_FINISH
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  blocks_in_use;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     iw;
  logic [CW-1:0]     ew;
  logic [CW-1:0]     nwords;
  logic              rv;
  logic [LIMW-1:0]   carry;
  logic [LEN_W-1:0]  need;
  logic [LIMW-1:0]   cur;
  logic [LIMW-1:0]   rend;
  logic              set_val;
  logic [STAT_W-1:0] res_status;
  logic [BLK_W-1:0]  res_index;
  logic              res_bit;
  logic [STAT_W-1:0] out_status;
  logic [BLK_W-1:0]  out_index;
  logic              out_bit;

  // RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] rdata;

  bcba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // Request decode
  op_t              in_op;
  logic [BLK_W-1:0] in_start;
  logic [LEN_W-1:0] in_len;
  logic [LEN_W-1:0] need_in;
  logic [LIMW-1:0]  lim;
  logic [PW-1:0]    lim_p;
  logic [PW-1:0]    start_p;
  logic [PW-1:0]    len_p;
  logic             start_oob;
  logic             range_oob;
  logic             in_oob;
  logic [CW-1:0]    nwords_in;

  assign in_op    = op_t'(s_tuser);
  assign in_start = s_tdata[BLK_W-1:0];
  assign in_len   = s_tdata[BLK_W +: LEN_W];
  assign need_in  = (in_len == '0) ? LEN_W'(1) : in_len;
  assign lim      = (PW'(blocks_in_use) > PW'(NUM_BLOCKS)) ? LIMW'(NUM_BLOCKS)
                                                           : LIMW'(blocks_in_use);
  assign lim_p     = PW'(lim);
  assign start_p   = PW'(in_start);
  assign len_p     = PW'(in_len);
  assign start_oob = start_p >= lim_p;
  assign range_oob = start_oob || (start_p + len_p > lim_p);
  assign in_oob    = (in_op == OP_TEST) ? start_oob : (in_op != OP_ALLOC) && range_oob;
  assign nwords_in = CW'((lim_p + PW'(WORD_BITS - 1)) >> WB);

  // Scan of one word: run of free blocks ending at each bit, carried across words
  logic [PW-1:0]        base;
  logic [WORD_BITS-1:0] free_bits;
  logic [LIMW-1:0]      run [WORD_BITS];
  logic [WORD_BITS-1:0] hit;
  logic                 found;
  logic [WB-1:0]        fj;
  logic [LIMW-1:0]      scan_first;

  always_comb begin
    logic [JW-1:0] lp;
    logic [PW-1:0] first_p;
    base = PW'(ew) << WB;
    for (int j = 0; j < WORD_BITS; j++) begin
      free_bits[j] = !rdata[j] && (base + PW'(j) < lim_p);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      lp = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (k <= j && !free_bits[k]) begin
          lp = JW'(k + 1);
        end
      end
      run[j] = (lp == '0) ? LIMW'(PW'(carry) + PW'(j + 1)) : LIMW'(JW'(j + 1) - lp);
      hit[j] = PW'(run[j]) >= PW'(need);
    end
    found = 1'b0;
    fj    = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        found = 1'b1;
        fj    = WB'(j);
      end
    end
    first_p    = base + PW'(fj) + PW'(1) - PW'(need);
    scan_first = LIMW'(first_p);
  end

  // Range read-modify-write of one word
  logic [PW-1:0]        word_base;
  logic [PW-1:0]        next_base;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rmw_wdata;
  logic                 scan_issue;

  always_comb begin
    word_base = PW'(cur >> WB) << WB;
    next_base = word_base + PW'(WORD_BITS);
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (word_base + PW'(j) >= PW'(cur)) && (word_base + PW'(j) < PW'(rend));
    end
    rmw_wdata = set_val ? (rdata | mask) : (rdata & ~mask);
  end

  assign scan_issue = iw < nwords;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_SCAN: begin
        ram_re    = scan_issue;
        ram_raddr = AW'(iw);
      end
      S_RMW_RD, S_TEST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(cur >> WB);
      end
      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur >> WB);
        ram_wdata = rmw_wdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      blocks_in_use <= CFG_RESET;
      m_tvalid      <= 1'b0;
      rv            <= 1'b0;
    end else begin
      if (cfg_wen) begin
        blocks_in_use <= cfg_wdata;
      end
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            res_status <= in_oob ? ST_RANGE : ST_OK;
            res_index  <= in_start;
            res_bit    <= 1'b0;
            cur        <= LIMW'(in_start);
            rend       <= LIMW'(start_p + len_p);
            set_val    <= (in_op == OP_MARK);
            case (in_op)
              OP_ALLOC: begin
                need   <= need_in;
                nwords <= nwords_in;
                iw     <= '0;
                rv     <= 1'b0;
                carry  <= '0;
                state  <= S_SCAN;
              end
              OP_FREE, OP_MARK: begin
                if (in_oob || in_len == '0) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_RMW_RD;
                end
              end
              OP_TEST: begin
                if (in_oob) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_TEST_RD;
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          rv <= scan_issue;
          ew <= iw;
          if (scan_issue) begin
            iw <= iw + CW'(1);
          end
          if (rv) begin
            if (found) begin
              res_index <= BLK_W'(scan_first);
              cur       <= scan_first;
              rend      <= LIMW'(PW'(scan_first) + PW'(need));
              set_val   <= 1'b1;
              state     <= S_RMW_RD;
            end else if (ew + CW'(1) == nwords) begin
              res_status <= ST_NOSPACE;
              state      <= S_FINISH;
            end else begin
              carry <= run[WORD_BITS-1];
            end
          end else if (!scan_issue) begin
            res_status <= ST_NOSPACE;
            state      <= S_FINISH;
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          if (next_base >= PW'(rend)) begin
            state <= S_FINISH;
          end else begin
            cur   <= LIMW'(next_base);
            state <= S_RMW_RD;
          end
        end
        S_TEST_RD: state <= S_TEST_BIT;
        S_TEST_BIT: begin
          res_bit <= rdata[cur[WB-1:0]];
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_index  <= res_index;
            out_bit    <= res_bit;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {(OUT_DATA_W - OUT_BIT_POS - 1)'(0), out_bit, out_index, out_status};

endmodule

// File: design/bcba_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module bcba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/bcba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bcba_pkg.
module bcba_checker
  import bcba_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no request taken during the clearing pass
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("ready during clearing pass");

  // one request in flight
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STAT_W-1:0] == ST_OK || m_tdata[STAT_W-1:0] == ST_NOSPACE ||
                  m_tdata[STAT_W-1:0] == ST_RANGE))
    else $error("bad status code");

  a_bit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_BIT_POS] |-> m_tdata[STAT_W-1:0] == ST_OK)
    else $error("bit value set on failed request");

endmodule

bind bitmap_contiguous_block_allocator_core bcba_checker u_bcba_checker (.*);
